// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Every check runs on the rising edge of
// i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

// ----- rtl/core/sud_pkg.sv -----
// ----------------------------------------------------------------------------
// sud_pkg
// Shared constants and types of the sorted union with duplicate removal.
// ----------------------------------------------------------------------------
`default_nettype none

package sud_pkg;

    // Number of storage cells in the sorted chain (2 to 64).
    localparam int unsigned DEPTH   = 64;
    // Width of one stored value.
    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic insert;   // place the new value at its sorted position
        logic shift;    // move every entry one cell toward cell zero
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_union_dedup.sv -----
// An unmarked request is done at the edge that accepts it; after a request
// marked last, the results follow from the next cycle on, one per cycle, one
// for each of the N distinct values (at most 64), with busy high while they
// stream out. Throughput: one request per cycle while collecting, set by the
// compare-and-shift insert in the cell chain; the receiver cannot stall.
// Reset (synchronous, active low) empties the chain and clears overflow.
// ----------------------------------------------------------------------------
// sorted_union_dedup
// Keeps the distinct signed values of one run in ascending order in a chain of
// cells, drops duplicates and, once it is full, new values (raising overflow),
// and streams the sorted set out when the request marked last arrives.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_union_dedup (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire signed [31:0]       i_value,
    input  wire                     i_last,
    output logic                    o_strobe,
    output logic signed [31:0]      o_value_res,
    output logic                    o_last_res,
    output logic                    o_overflow
);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic                 r_overflow;
    logic                 n_overflow;

    sud_pkg::t_value            w_value [sud_pkg::DEPTH];
    logic [sud_pkg::DEPTH-1:0]  w_valid;
    logic [sud_pkg::DEPTH-1:0]  w_less;
    logic [sud_pkg::DEPTH-1:0]  w_eq;

    sud_pkg::t_cell_ctrl  w_ctrl;
    logic                 w_accept;
    logic                 w_dup;
    logic                 w_full;

    // Request handshake and insert decision.
    assign busy     = (r_state == ST_EMIT);
    assign w_accept = start && !busy;
    assign w_dup    = |w_eq;
    assign w_full   = w_valid[sud_pkg::DEPTH-1];

    assign w_ctrl.insert = w_accept && !w_dup && !w_full;
    assign w_ctrl.shift  = busy;

    // Chain of cells; each sees its left and right neighbor.
    for (genvar g = 0; g < sud_pkg::DEPTH; g++) begin : g_cell
        logic            w_left_less;
        sud_pkg::t_value w_left_value;
        logic            w_left_valid;
        sud_pkg::t_value w_right_value;
        logic            w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_less  = 1'b1;
            assign w_left_value = i_value;
            assign w_left_valid = 1'b1;
        end else begin : g_inner
            assign w_left_less  = w_less[g-1];
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == sud_pkg::DEPTH - 1) begin : g_end
            assign w_right_value = i_value;
            assign w_right_valid = 1'b0;
        end else begin : g_mid
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        sud_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new_value   (i_value),
            .i_left_less   (w_left_less),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_less        (w_less[g]),
            .o_eq          (w_eq[g])
        );
    end

    // Results come straight from the head cell while emitting.
    assign o_strobe    = busy && w_valid[0];
    assign o_value_res = w_value[0];
    assign o_last_res  = !w_valid[1];
    assign o_overflow  = r_overflow;

    // Sequencing between collection and emission.
    always_comb begin
        n_state    = r_state;
        n_overflow = r_overflow;
        case (r_state)
            ST_COLLECT: begin
                if (w_accept && !w_dup && w_full) begin
                    n_overflow = 1'b1;
                end
                if (w_accept && i_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_valid[1]) begin
                    n_state    = ST_COLLECT;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_COLLECT;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    // Checks on the sequencing and the chain.
    `ASSERT_SAME(a_emit_has_head, busy, w_valid[0])
    `ASSERT_NEXT(a_last_ends_emit, o_strobe && o_last_res, !busy && !w_valid[0])
    `ASSERT_NEXT(a_last_starts_emit, start && !busy && i_last, busy)
    `ASSERT_SAME(a_chain_prefix, w_valid[1], w_valid[0])

endmodule

`default_nettype wire

// ----- rtl/core/sud_cell.sv -----
// ----------------------------------------------------------------------------
// sud_cell
// One cell of the sorted chain. It holds one value and its valid bit, compares
// the value against the incoming request, and on insert either keeps its
// value, takes the new value, or takes its left neighbor's value. On shift it
// takes its right neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module sud_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  sud_pkg::t_cell_ctrl  i_ctrl,
    input  sud_pkg::t_value      i_new_value,
    input  wire                  i_left_less,
    input  sud_pkg::t_value      i_left_value,
    input  wire                  i_left_valid,
    input  sud_pkg::t_value      i_right_value,
    input  wire                  i_right_valid,
    output sud_pkg::t_value      o_value,
    output logic                 o_valid,
    output logic                 o_less,
    output logic                 o_eq
);

    sud_pkg::t_value r_value;
    sud_pkg::t_value n_value;
    logic            r_valid;
    logic            n_valid;

    // Compare the stored value against the new request.
    assign o_less  = r_valid && (r_value < i_new_value);
    assign o_eq    = r_valid && (r_value == i_new_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    // Next contents of the cell.
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.insert && !o_less) begin
            if (i_left_less) begin
                // This cell is the insertion point.
                n_value = i_new_value;
                n_valid = 1'b1;
            end else begin
                // Everything from the insertion point on moves right by one.
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
        end
    end

    // The valid bit is control state; the value needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// ----- sim/sorted_union_dedup_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_union_dedup_tb
// Self-checking bench for the sorted union block. A table of directed
// requests covers the value extremes, duplicates and marked runs. Random runs
// follow: a long wide run, two that fill the store exactly, the second then
// overflowing by one, and many short runs in narrow and wide value windows.
// A behavioral model of the sorted store predicts every result, and each
// strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module sorted_union_dedup_tb;

    // One predicted result of a run.
    typedef struct packed {
        sud_pkg::t_value value;
        logic            last;
        logic            ovf;
    } t_sorted_out;

    // One directed request, with a typed-in single result where it is obvious.
    typedef struct packed {
        sud_pkg::t_value value;
        logic            last;
        logic            typed;
        sud_pkg::t_value want;
    } t_row;

    localparam int N_ROWS                = 20;
    localparam int RANDOM_ITEMS          = 240;
    localparam sud_pkg::t_value V_MIN    = 32'sh8000_0000;
    localparam sud_pkg::t_value V_MAX    = 32'sh7fff_ffff;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    sud_pkg::t_value i_value = '0;
    logic            i_last = 1'b0;
    logic            o_strobe;
    sud_pkg::t_value o_value_res;
    logic            o_last_res;
    logic            o_overflow;

    // Typed-in expectation that travels with the request on the bus.
    logic            row_typed = 1'b0;
    sud_pkg::t_value row_want = '0;

    // Model of the block: distinct values in ascending order.
    sud_pkg::t_value held_values [sud_pkg::DEPTH];
    int              held_count = 0;
    logic            held_dropped = 1'b0;

    t_sorted_out expected_sorted [$];
    t_row        directed_rows [N_ROWS];

    int idle_pct = 0;
    int errors = 0;
    int requests_done = 0;
    int results_seen = 0;
    int runs_done = 0;
    int overflow_runs = 0;

    sorted_union_dedup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_strobe    (o_strobe),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Append one predicted result behind the ones already waiting.
    function automatic void queue_expected(input t_sorted_out r);
        expected_sorted.insert(expected_sorted.size(), r);
    endfunction

    // Insert one value into the model store and, on a marked request, queue
    // the whole sorted set when post is set.
    function automatic void fold_request(input sud_pkg::t_value v, input logic lst,
                                         input logic post);
        int pos;
        pos = 0;
        while (pos < held_count && held_values[pos] < v)
            pos++;
        if (!(pos < held_count && held_values[pos] == v)) begin
            if (held_count >= sud_pkg::DEPTH) begin
                held_dropped = 1'b1;
            end else begin
                for (int i = held_count; i > pos; i--)
                    held_values[i] = held_values[i - 1];
                held_values[pos] = v;
                held_count++;
            end
        end
        if (lst) begin
            if (post) begin
                for (int k = 0; k < held_count; k++)
                    queue_expected('{held_values[k], k == held_count - 1,
                                     held_dropped});
            end
            held_count = 0;
            held_dropped = 1'b0;
        end
    endfunction

    // Check each strobed result, then fold in any request taken at this edge.
    always @(posedge i_clk) begin : check_results
        t_sorted_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_sorted.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value=%0d last=%b overflow=%b",
                         $time, o_value_res, o_last_res, o_overflow);
            end else begin
                want = expected_sorted.pop_front();
                results_seen++;
                if (want.last) begin
                    runs_done++;
                    if (want.ovf)
                        overflow_runs++;
                end
                if (o_value_res !== want.value) begin
                    errors++;
                    $display("%0t: value_res expected %0d, got %0d",
                             $time, want.value, o_value_res);
                end
                if (o_last_res !== want.last) begin
                    errors++;
                    $display("%0t: last_res expected %b, got %b",
                             $time, want.last, o_last_res);
                end
                if (o_overflow !== want.ovf) begin
                    errors++;
                    $display("%0t: overflow expected %b, got %b",
                             $time, want.ovf, o_overflow);
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            requests_done++;
            fold_request(i_value, i_last, !row_typed);
            if (row_typed)
                queue_expected('{row_want, 1'b1, 1'b0});
        end
    end

    // Present one request after a random idle gap and hold it until taken.
    task automatic send_request(input sud_pkg::t_value v, input logic lst,
                                input logic typed, input sud_pkg::t_value want);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_value <= $urandom;
            i_last <= $urandom_range(0, 1);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_value <= v;
        i_last <= lst;
        row_typed <= typed;
        row_want <= want;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // One run of requests ending in a marked one. A walk of 1 or 2 first
    // fills the store with distinct values, then repeats them; a walk of 2
    // ends on a new value that cannot be stored.
    task automatic send_run(input int n_items, input logic [31:0] span, input int walk);
        sud_pkg::t_value base;
        sud_pkg::t_value v;
        base = $urandom;
        for (int k = 0; k < n_items; k++) begin
            if (walk != 0 && k < sud_pkg::DEPTH) begin
                v = base + sud_pkg::t_value'((k * 37) % sud_pkg::DEPTH);
            end else if (walk != 0) begin
                if (walk == 2 && k == n_items - 1)
                    v = base + sud_pkg::t_value'(sud_pkg::DEPTH);
                else
                    v = base + sud_pkg::t_value'($urandom_range(0, sud_pkg::DEPTH - 1));
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: v = V_MIN;
                            1: v = V_MAX;
                            2: v = '0;
                            default: v = -1;
                        endcase
                    end
                    1: v = $urandom;
                    default: v = base + sud_pkg::t_value'($urandom_range(0, span));
                endcase
            end
            send_request(v, k == n_items - 1, 1'b0, '0);
        end
    endtask

    // Main sequence: reset, directed table, random runs, drain and verdict.
    initial begin : stimulus
        int random_start;
        int run_no;
        int waited;
        logic [31:0] span;

        directed_rows = '{
            '{V_MIN,            1'b1, 1'b1, V_MIN},
            '{V_MAX,            1'b1, 1'b1, V_MAX},
            '{32'sd0,           1'b1, 1'b1, 32'sd0},
            '{-32'sd1,          1'b1, 1'b1, -32'sd1},
            '{32'sd7,           1'b0, 1'b0, 32'sd0},
            '{32'sd7,           1'b0, 1'b0, 32'sd0},
            '{-32'sd7,          1'b0, 1'b0, 32'sd0},
            '{32'sd7,           1'b1, 1'b0, 32'sd0},
            '{V_MAX,            1'b0, 1'b0, 32'sd0},
            '{V_MIN,            1'b0, 1'b0, 32'sd0},
            '{32'sd0,           1'b0, 1'b0, 32'sd0},
            '{-32'sd1,          1'b0, 1'b0, 32'sd0},
            '{32'sd1,           1'b0, 1'b0, 32'sd0},
            '{32'sh4000_0000,   1'b0, 1'b0, 32'sd0},
            '{V_MAX,            1'b0, 1'b0, 32'sd0},
            '{V_MIN,            1'b0, 1'b0, 32'sd0},
            '{32'shbfff_ffff,   1'b0, 1'b0, 32'sd0},
            '{-32'sd1,          1'b1, 1'b0, 32'sd0},
            '{32'sd5,           1'b0, 1'b0, 32'sd0},
            '{32'sd5,           1'b1, 1'b0, 32'sd0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table with the request line held busy back to back.
        for (int r = 0; r < N_ROWS; r++)
            send_request(directed_rows[r].value, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].want);

        // Random runs; the idle rate steps through its phases run by run.
        random_start = requests_done;
        run_no = 0;
        while (requests_done - random_start < RANDOM_ITEMS) begin
            case (run_no % 4)
                1: idle_pct = 56;
                3: idle_pct = 33;
                default: idle_pct = 0;
            endcase
            case ($urandom_range(0, 3))
                0: span = 3;
                1: span = 15;
                2: span = 255;
                default: span = '1;
            endcase
            case (run_no)
                0: send_run(68, '1, 0);
                1: send_run(sud_pkg::DEPTH + 6, 0, 1);
                2: send_run(sud_pkg::DEPTH + 6, 0, 2);
                default: send_run($urandom_range(1, 12), span, 0);
            endcase
            run_no++;
        end
        start <= 1'b0;

        // Wait for every predicted result, then a full output burst more.
        waited = 0;
        while (expected_sorted.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (sud_pkg::DEPTH + 8) @(posedge i_clk);
        if (expected_sorted.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived, next value %0d",
                     $time, expected_sorted.size(), expected_sorted[0].value);
        end

        $display("Ran %0d requests in %0d runs, %0d of them past the store size.",
                 requests_done, runs_done, overflow_runs);
        $display("Checked %0d sorted results, %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("sorted_union_dedup regression: pass");
        end else begin
            $display("sorted_union_dedup regression: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #5_000_000;
        $display("sorted_union_dedup regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sud_pkg.sv
rtl/core/sud_cell.sv
rtl/core/sorted_union_dedup.sv
sim/sorted_union_dedup_tb.sv
